// ===== hdl/cfe_pkg.sv =====
// ----------------------------------------------------------------------------
// cfe_pkg
// Shared constants, codes, controller/datapath command types and helper
// functions for the clock field editor.
// ----------------------------------------------------------------------------
package cfe_pkg;

  localparam int NFIELDS = 7;

  localparam logic [2:0] F_SEC   = 3'd0;
  localparam logic [2:0] F_MIN   = 3'd1;
  localparam logic [2:0] F_HOUR  = 3'd2;
  localparam logic [2:0] F_WDAY  = 3'd3;
  localparam logic [2:0] F_DATE  = 3'd4;
  localparam logic [2:0] F_MONTH = 3'd5;
  localparam logic [2:0] F_YEAR  = 3'd6;
  localparam logic [2:0] NO_EDIT = 3'd7;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_NEXT   = 2'd1;
  localparam logic [1:0] OP_CHANGE = 2'd2;

  localparam logic [7:0] FEB_DAYS      = 8'd28;
  localparam logic [7:0] FEB_LEAP_DAYS = 8'd29;
  localparam logic [7:0] MONTH_OR      = 8'd30;
  localparam logic [7:0] FEB           = 8'd2;
  localparam logic [7:0] JUL           = 8'd7;
  localparam logic [7:0] YEAR_BASE     = 8'd12;
  localparam logic [7:0] MONTH_SHIFT   = 8'd12;
  localparam logic [11:0] RECIP_3      = 12'd2731;
  localparam logic [13:0] RECIP_7      = 14'd9363;
  localparam logic [7:0] RECIP_10      = 8'd205;
  localparam logic [2:0] WDAY_ZERO     = 3'd7;

  typedef logic [7:0] fld_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WD1,
    S_WD2,
    S_WD3,
    S_WD4,
    S_WD5,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic wd1;
    logic wd2;
    logic wd3;
    logic wd4;
    logic wd5;
    logic out_first;
    logic out_next;
  } cmd_t;

  typedef struct packed {
    logic out_last;
  } sts_t;

  function automatic fld_t lim_lo(input logic [2:0] f);
    fld_t r;
    unique case (f)
      F_SEC, F_MIN, F_HOUR: r = 8'd0;
      default:              r = 8'd1;
    endcase
    return r;
  endfunction

  function automatic fld_t lim_hi(input logic [2:0] f);
    fld_t r;
    unique case (f)
      F_SEC, F_MIN: r = 8'd59;
      F_HOUR:       r = 8'd23;
      F_WDAY:       r = 8'd7;
      F_DATE:       r = 8'd31;
      F_MONTH:      r = 8'd12;
      F_YEAR:       r = 8'd99;
      default:      r = 8'd0;
    endcase
    return r;
  endfunction

  function automatic fld_t to_bcd(input fld_t n);
    logic [15:0] p;
    logic [4:0]  tens;
    logic [7:0]  tens10;
    logic [7:0]  ones;
    p      = n * RECIP_10;
    tens   = p[15:11];
    tens10 = {2'b0, tens, 1'b0} + {tens, 3'b0};
    ones   = n - tens10;
    return {tens[3:0], 4'b0} + {4'b0, ones[3:0]};
  endfunction

endpackage

// ===== hdl/cfe_ctrl.sv =====
// ----------------------------------------------------------------------------
// cfe_ctrl
// Sequencer: takes one item, runs the update and weekday steps, then
// hands out the result bytes one per handshake.
// ----------------------------------------------------------------------------
module cfe_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output cfe_pkg::cmd_t cmd,
  input  cfe_pkg::sts_t sts
);
  import cfe_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_WD1;
      end
      S_WD1: begin
        cmd.wd1   = 1'b1;
        state_nxt = S_WD2;
      end
      S_WD2: begin
        cmd.wd2   = 1'b1;
        state_nxt = S_WD3;
      end
      S_WD3: begin
        cmd.wd3   = 1'b1;
        state_nxt = S_WD4;
      end
      S_WD4: begin
        cmd.wd4   = 1'b1;
        state_nxt = S_WD5;
      end
      S_WD5: begin
        cmd.wd5       = 1'b1;
        cmd.out_first = 1'b1;
        state_nxt     = S_EMIT;
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (sts.out_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.out_next = 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== hdl/cfe_dp.sv =====
// ----------------------------------------------------------------------------
// cfe_dp
// Datapath: clock fields, edit cursor, wrap logic, weekday pipeline and
// the output byte register.
// ----------------------------------------------------------------------------
module cfe_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  cfe_pkg::cmd_t     cmd,
  output cfe_pkg::sts_t     sts,
  input  logic [1:0]        in_op,
  input  logic [2:0]        in_field_index,
  input  logic [7:0]        in_bcd_byte,
  input  logic signed [5:0] in_step,
  output logic [7:0]        out_bus_byte,
  output logic              out_is_write,
  output logic              out_last,
  output logic [2:0]        out_edit_field,
  output logic [2:0]        out_weekday
);
  import cfe_pkg::*;

  fld_t              fld_r [NFIELDS];
  logic [2:0]        cur_r;
  logic [1:0]        op_r;
  logic [2:0]        fi_r;
  logic [7:0]        bcd_r;
  logic signed [5:0] step_r;
  logic              run_r;
  logic [2:0]        idx_r;

  logic [10:0] t_r;
  logic [10:0] s1_r;
  logic [9:0]  q3_r;
  logic        neg_r;
  logic [10:0] u_r;
  logic [7:0]  q7_r;
  logic [2:0]  wd_r;

  logic [7:0] byte_r;
  logic       wr_r;
  logic       last_r;

  logic [2:0]  rd_idx;
  fld_t        rd_val;
  fld_t        bin;
  fld_t        mon;
  fld_t        mon_adj;
  fld_t        mdays;
  fld_t        hi;
  fld_t        lo;
  fld_t        sum8;
  fld_t        v1;
  fld_t        v2;
  logic [2:0]  cur_nxt;
  logic        run;

  logic        a;
  fld_t        y8;
  fld_t        m8;
  logic [12:0] m31;
  logic [10:0] s1;
  logic [22:0] p3;
  logic [11:0] s;
  logic [11:0] s_abs;
  logic [24:0] p7;
  logic [10:0] q7x;
  logic [2:0]  rem;

  assign rd_idx = cmd.exec ? cur_r : idx_r;
  assign rd_val = fld_r[rd_idx];
  assign bin    = {1'b0, bcd_r[7:4], 3'b0} + {3'b0, bcd_r[7:4], 1'b0} + {4'b0, bcd_r[3:0]};
  assign run    = (op_r == OP_CHANGE) && (cur_r != NO_EDIT);

  // days in month for the date limit
  always_comb begin
    mon     = fld_r[F_MONTH];
    mon_adj = (mon > JUL) ? mon + 8'd1 : mon;
    if (mon == FEB) begin
      mdays = (fld_r[F_YEAR][1:0] != 2'b00) ? FEB_DAYS : FEB_LEAP_DAYS;
    end else begin
      mdays = mon_adj | MONTH_OR;
    end
  end

  // wrap the edited field
  always_comb begin
    hi   = (cur_r == F_DATE) ? mdays : lim_hi(cur_r);
    lo   = lim_lo(cur_r);
    sum8 = rd_val + {{2{step_r[5]}}, step_r};
    v1   = ($signed(sum8) > $signed(hi)) ? lo : sum8;
    v2   = ($signed(v1) < $signed(lo)) ? hi : v1;
  end

  always_comb begin
    case (cur_r) inside
      F_HOUR, F_MIN:   cur_nxt = cur_r - 3'd1;
      F_SEC:           cur_nxt = F_DATE;
      F_DATE, F_MONTH: cur_nxt = cur_r + 3'd1;
      default:         cur_nxt = F_HOUR;
    endcase
  end

  // weekday arithmetic
  always_comb begin
    a     = !($signed(fld_r[F_MONTH]) > $signed(FEB));
    y8    = YEAR_BASE + fld_r[F_YEAR] - {7'b0, a};
    m8    = fld_r[F_MONTH] + (a ? MONTH_SHIFT : 8'd0) - FEB;
    m31   = {m8, 5'b0} - {5'b0, m8};
    s1    = {{3{fld_r[F_DATE][7]}}, fld_r[F_DATE]} + {3'b0, y8} + {5'b0, y8[7:2]};
    p3    = t_r * RECIP_3;
    s     = {s1_r[10], s1_r} + {2'b0, q3_r};
    s_abs = 12'd0 - s;
    p7    = u_r * RECIP_7;
    q7x   = {q7_r, 3'b0} - {3'b0, q7_r};
    rem   = u_r[2:0] - q7x[2:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NFIELDS; i++) begin
        fld_r[i] <= '0;
      end
      cur_r <= NO_EDIT;
    end else if (cmd.exec) begin
      unique case (op_r)
        OP_LOAD: begin
          if (fi_r != NO_EDIT) begin
            fld_r[fi_r] <= bin;
          end
        end
        OP_NEXT: cur_r <= cur_nxt;
        OP_CHANGE: begin
          if (cur_r != NO_EDIT) begin
            fld_r[cur_r] <= v2;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_op;
      fi_r   <= in_field_index;
      bcd_r  <= in_bcd_byte;
      step_r <= in_step;
    end
    if (cmd.exec) begin
      run_r <= run;
    end
    if (cmd.wd1) begin
      t_r  <= m31[12:2];
      s1_r <= s1;
    end
    if (cmd.wd2) begin
      q3_r <= p3[22:13];
    end
    if (cmd.wd3) begin
      neg_r <= s[11];
      u_r   <= s[11] ? s_abs[10:0] : s[10:0];
    end
    if (cmd.wd4) begin
      q7_r <= p7[23:16];
    end
    if (cmd.wd5) begin
      if (rem == 3'd0) begin
        wd_r <= WDAY_ZERO;
      end else begin
        wd_r <= neg_r ? 3'd0 - rem : rem;
      end
    end
    if (cmd.out_first) begin
      idx_r <= cur_r;
      if (run_r) begin
        byte_r <= {5'b0, cur_r};
        wr_r   <= 1'b1;
        last_r <= 1'b0;
      end else begin
        byte_r <= '0;
        wr_r   <= 1'b0;
        last_r <= 1'b1;
      end
    end else if (cmd.out_next) begin
      if (idx_r == F_SEC) begin
        byte_r <= '0;
        last_r <= 1'b1;
      end else begin
        byte_r <= to_bcd(rd_val);
        last_r <= (idx_r == F_YEAR);
        idx_r  <= idx_r + 3'd1;
      end
    end
  end

  assign sts.out_last   = last_r;
  assign out_bus_byte   = byte_r;
  assign out_is_write   = wr_r;
  assign out_last       = last_r;
  assign out_edit_field = cur_r;
  assign out_weekday    = wd_r;

endmodule

// ===== hdl/clock_field_editor.sv =====
// ----------------------------------------------------------------------------
// clock_field_editor
// Clock fields from seconds to year with an edit cursor; load, cursor advance and
// wrapping field change, with the BCD write run for the clock chip.
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_stall with in_op, in_field_index,
//   in_bcd_byte, in_step. one item is taken only while the block is idle.
//   result channel: out_valid / out_stall with out_bus_byte, out_is_write,
//   out_last, out_edit_field, out_weekday. a change while editing gives
//   the start index and the BCD fields up to the year (or one zero byte
//   when seconds are edited); every other item gives one status byte.
//   out_last marks the final byte of an item.
//   the first result follows the field update and the weekday pipeline
//   (two reciprocal multiplies for the divides by 12 and by 7).
//   each item gives 1..7 result bytes, one byte per cycle from the
//   output register while out_stall is low; the next item is taken only
//   after the last byte of an item is out.
//   reset: fields clear to zero, cursor goes to not editing, no result.
//   while out_stall is high the current byte holds and the block waits.
// ----------------------------------------------------------------------------
module clock_field_editor (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_op,
  input  logic [2:0]        in_field_index,
  input  logic [7:0]        in_bcd_byte,
  input  logic signed [5:0] in_step,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_bus_byte,
  output logic              out_is_write,
  output logic              out_last,
  output logic [2:0]        out_edit_field,
  output logic [2:0]        out_weekday
);
  import cfe_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cfe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  cfe_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_op          (in_op),
    .in_field_index (in_field_index),
    .in_bcd_byte    (in_bcd_byte),
    .in_step        (in_step),
    .out_bus_byte   (out_bus_byte),
    .out_is_write   (out_is_write),
    .out_last       (out_last),
    .out_edit_field (out_edit_field),
    .out_weekday    (out_weekday)
  );

endmodule

// ===== hdl/cfe_checker.sv =====
// ----------------------------------------------------------------------------
// cfe_checker
// Port-level checks for the clock field editor, bound to the top level.
// ----------------------------------------------------------------------------
module cfe_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic [1:0]        in_op,
  input logic [2:0]        in_field_index,
  input logic [7:0]        in_bcd_byte,
  input logic signed [5:0] in_step,
  input logic              out_valid,
  input logic              out_stall,
  input logic [7:0]        out_bus_byte,
  input logic              out_is_write,
  input logic              out_last,
  input logic [2:0]        out_edit_field,
  input logic [2:0]        out_weekday
);

  // held byte stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_bus_byte) && $stable(out_last))
    else $error("stalled result changed");

  // busy after an item is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while busy");

  // a write run continues until its last byte
  a_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> out_valid && out_is_write)
    else $error("write run broken off");

  // status results are single
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_write |-> out_last && (out_bus_byte == 8'd0))
    else $error("bad status result");

  // no input while results are pending
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open during output");

endmodule

bind clock_field_editor cfe_checker u_chk (.*);

// ===== sim/clock_field_editor_test.sv =====
// ----------------------------------------------------------------------------
// clock_field_editor_test
// Self-checking bench for the clock field editor. Items go in over the
// valid/stall input channel with random gaps. A predictor keeps its own
// copy of the clock fields and the edit cursor, and for each accepted item
// it queues the expected write run or status byte. Every result byte is
// compared field by field with the oldest expected byte. Directed items
// cover field extremes, the ignored field index and op, edits while not
// editing, the cursor walk and wrap at both limits. Random edit sequences
// follow, with bursts of stall on the result side.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module clock_field_editor_test;
  import cfe_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [2:0] NO_FIELD  = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct {
    logic [7:0] bus_byte;
    logic       is_write;
    logic       last;
    logic [2:0] edit_field;
    logic [2:0] weekday;
  } bus_item_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_op = OP_LOAD;
  logic [2:0]        in_field_index = F_SEC;
  logic [7:0]        in_bcd_byte = 8'd0;
  logic signed [5:0] in_step = 6'sd0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [7:0]        out_bus_byte;
  logic              out_is_write;
  logic              out_last;
  logic [2:0]        out_edit_field;
  logic [2:0]        out_weekday;

  logic [7:0]  clock_fields [0:6];
  logic [2:0]  cursor_pos;
  bus_item_t   bus_queue [$];
  bus_item_t   got_item;
  int          error_count = 0;
  int unsigned cycle_count = 0;
  int          stall_left = 0;
  logic        calm = 1'b0;

  clock_field_editor uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_field_index (in_field_index),
    .in_bcd_byte    (in_bcd_byte),
    .in_step        (in_step),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_bus_byte   (out_bus_byte),
    .out_is_write   (out_is_write),
    .out_last       (out_last),
    .out_edit_field (out_edit_field),
    .out_weekday    (out_weekday)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int s8(input logic [7:0] v);
    return $signed(v);
  endfunction

  function automatic int field_floor(input logic [2:0] f);
    case (f)
      F_SEC, F_MIN, F_HOUR: return 0;
      default: return 1;
    endcase
  endfunction

  function automatic int field_ceiling(input logic [2:0] f);
    case (f)
      F_SEC, F_MIN: return 59;
      F_HOUR: return 23;
      F_WDAY: return 7;
      F_DATE: return 31;
      F_MONTH: return 12;
      F_YEAR: return 99;
      default: return 0;
    endcase
  endfunction

  function automatic logic [7:0] bcd_of(input logic [7:0] n);
    int t;
    t = ((n / 10) << 4) + (n % 10);
    return t[7:0];
  endfunction

  function automatic int date_max();
    logic [7:0] mo;
    mo = clock_fields[F_MONTH];
    if (mo == 8'd2) return (clock_fields[F_YEAR][1:0] != 2'd0) ? 28 : 29;
    if (mo > 8'd7) mo = mo + 8'd1;
    return s8(mo | 8'd30);
  endfunction

  function automatic logic [2:0] weekday_of();
    int mo, a, y, m, r;
    mo = s8(clock_fields[F_MONTH]);
    a = (mo > 2) ? 0 : 1;
    y = (12 + s8(clock_fields[F_YEAR]) - a) & 255;
    m = (mo + 12 * a - 2) & 255;
    r = (s8(clock_fields[F_DATE]) + y + y / 4 + (31 * m) / 12) % 7;
    if (r == 0) r = 7;
    return r[2:0];
  endfunction

  function automatic void push_byte(input logic [7:0] b, input logic w, input logic l);
    bus_item_t e;
    e.bus_byte   = b;
    e.is_write   = w;
    e.last       = l;
    e.edit_field = cursor_pos;
    e.weekday    = weekday_of();
    bus_queue.push_back(e);
  endfunction

  // updates the field copy and cursor, queues the bytes this item causes
  function automatic void predict_edit(input logic [1:0] op, input logic [2:0] fi,
                                       input logic [7:0] b, input logic signed [5:0] st);
    logic [2:0] c;
    logic [7:0] sum;
    int lo, hi, v, i;
    c = cursor_pos;
    if (op == OP_LOAD) begin
      if (fi != NO_FIELD) clock_fields[fi] = b[7:4] * 8'd10 + b[3:0];
    end else if (op == OP_NEXT) begin
      case (c)
        F_HOUR, F_MIN: cursor_pos = c - 3'd1;
        F_SEC: cursor_pos = F_DATE;
        F_DATE, F_MONTH: cursor_pos = c + 3'd1;
        default: cursor_pos = F_HOUR;
      endcase
    end else if (op == OP_CHANGE && c != NO_EDIT) begin
      lo = field_floor(c);
      hi = (c == F_DATE) ? date_max() : field_ceiling(c);
      sum = clock_fields[c] + {{2{st[5]}}, st};
      v = s8(sum);
      if (v > hi) v = lo;
      if (v < lo) v = hi;
      clock_fields[c] = v[7:0];
      push_byte({5'd0, c}, 1'b1, 1'b0);
      if (c == F_SEC) begin
        push_byte(8'd0, 1'b1, 1'b1);
      end else begin
        for (i = c; i <= F_YEAR; i++)
          push_byte(bcd_of(clock_fields[i]), 1'b1, i == F_YEAR);
      end
      return;
    end
    push_byte(8'd0, 1'b0, 1'b1);
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    error_count++;
  endtask

  task automatic send_edit(input logic [1:0] op, input logic [2:0] fi,
                           input logic [7:0] b, input logic signed [5:0] st);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_op          <= op;
    in_field_index <= fi;
    in_bcd_byte    <= b;
    in_step        <= st;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_edit(op, fi, b, st);
  endtask

  // result side stall bursts, started at random while not calm
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 17);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (bus_queue.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte %02h", out_bus_byte));
      end else begin
        got_item = bus_queue.pop_front();
        if (out_bus_byte !== got_item.bus_byte)
          report_mismatch($sformatf("bus_byte %02h, want %02h", out_bus_byte,
                                    got_item.bus_byte));
        if (out_is_write !== got_item.is_write)
          report_mismatch($sformatf("is_write %0b, want %0b", out_is_write,
                                    got_item.is_write));
        if (out_last !== got_item.last)
          report_mismatch($sformatf("last %0b, want %0b", out_last, got_item.last));
        if (out_edit_field !== got_item.edit_field)
          report_mismatch($sformatf("edit_field %0d, want %0d", out_edit_field,
                                    got_item.edit_field));
        if (out_weekday !== got_item.weekday)
          report_mismatch($sformatf("weekday %0d, want %0d", out_weekday,
                                    got_item.weekday));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // loads, ignored items and a change before any cursor move
  task automatic test_idle_ops();
    send_edit(OP_LOAD, F_SEC, 8'h00, 6'sd0);
    send_edit(OP_LOAD, F_MIN, 8'hFF, 6'sd0);
    send_edit(OP_LOAD, F_HOUR, 8'h59, 6'sd0);
    send_edit(OP_LOAD, F_WDAY, 8'hA5, 6'sd0);
    send_edit(OP_LOAD, F_DATE, 8'h31, 6'sd0);
    send_edit(OP_LOAD, F_MONTH, 8'h02, 6'sd0);
    send_edit(OP_LOAD, F_YEAR, 8'h96, 6'sd0);
    send_edit(OP_LOAD, NO_FIELD, 8'hFF, 6'sd0);
    send_edit(OP_UNUSED, NO_FIELD, 8'hFF, -6'sd16);
    send_edit(OP_CHANGE, F_SEC, 8'h00, 6'sd16);
  endtask

  // full cursor loop, with wrap at both limits on hour and date and at one limit on the others
  task automatic test_edit_walk();
    send_edit(OP_NEXT, F_SEC, 8'h00, 6'sd0);
    send_edit(OP_CHANGE, F_SEC, 8'h00, 6'sd16);
    send_edit(OP_CHANGE, F_SEC, 8'h00, -6'sd16);
    send_edit(OP_NEXT, F_SEC, 8'h00, 6'sd0);
    send_edit(OP_CHANGE, F_SEC, 8'h00, 6'sd16);
    send_edit(OP_NEXT, F_SEC, 8'h00, 6'sd0);
    send_edit(OP_CHANGE, F_SEC, 8'h00, -6'sd1);
    send_edit(OP_NEXT, F_SEC, 8'h00, 6'sd0);
    send_edit(OP_CHANGE, F_SEC, 8'h00, 6'sd1);
    send_edit(OP_CHANGE, F_SEC, 8'h00, -6'sd1);
    send_edit(OP_NEXT, F_SEC, 8'h00, 6'sd0);
    send_edit(OP_CHANGE, F_SEC, 8'h00, 6'sd16);
    send_edit(OP_NEXT, F_SEC, 8'h00, 6'sd0);
    send_edit(OP_CHANGE, F_SEC, 8'h00, 6'sd16);
    send_edit(OP_NEXT, F_SEC, 8'h00, 6'sd0);
  endtask

  // random edit sessions, mostly well-formed loads and changes
  task automatic test_random_edits(input int count);
    logic [1:0]        op;
    logic [2:0]        fi;
    logic [7:0]        b;
    logic signed [5:0] st;
    int                pick, n;
    for (n = 0; n < count; n++) begin
      if (n == count - 40) calm = 1'b1;
      pick = $urandom_range(0, 99);
      fi = 3'($urandom_range(0, 6));
      b = 8'($urandom_range(0, 255));
      st = 6'($urandom_range(0, 32) - 16);
      if (pick < 30) begin
        op = OP_LOAD;
        if ($urandom_range(0, 19) == 0) fi = NO_FIELD;
        else if ($urandom_range(0, 4) != 0)
          b = bcd_of(8'($urandom_range(field_floor(fi), field_ceiling(fi))));
      end else if (pick < 50) begin
        op = OP_NEXT;
      end else if (pick < 96) begin
        op = OP_CHANGE;
      end else begin
        op = OP_UNUSED;
      end
      send_edit(op, fi, b, st);
    end
  endtask

  initial begin
    for (int i = 0; i < 7; i++) clock_fields[i] = 8'd0;
    cursor_pos = NO_EDIT;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_idle_ops();
    test_edit_walk();
    test_random_edits(305);
    in_valid <= 1'b0;
    while (bus_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
